@@ design/ccrc_pkg.sv @@
package ccrc_pkg;

  localparam int unsigned MAX_CRC_WIDTH = 32;
  localparam int unsigned REM_W         = 32;
  localparam int unsigned WID_W         = 6;
  localparam int unsigned APB_AW        = 3;
  localparam int unsigned APB_DW        = 32;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [WID_W-1:0] CRC_WIDTH_RESET = 6'd8;
  localparam logic [REM_W-1:0] POLY_RESET      = 32'd7;

  localparam int unsigned WID_LIMIT =
    (MAX_CRC_WIDTH < REM_W) ? MAX_CRC_WIDTH : REM_W;

  typedef enum logic {
    REG_CRC_WIDTH = 1'b0,
    REG_POLY_LOW  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [REM_W-1:0] mask;
    logic [REM_W-1:0] poly;
  } crc_cfg_t;

  function automatic logic [WID_W-1:0] eff_width(input logic [WID_W-1:0] w);
    logic [WID_W-1:0] lim;
    lim = WID_W'(WID_LIMIT);
    return (w > lim) ? lim : w;
  endfunction

  function automatic logic [REM_W-1:0] width_mask(input logic [WID_W-1:0] w);
    logic [REM_W:0] one_hot;
    one_hot = (REM_W+1)'(1) << w;
    return REM_W'(one_hot - (REM_W+1)'(1));
  endfunction

endpackage

@@ design/ccrc_if.sv @@
interface ccrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ccrc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] remainder;
  logic        remainder_zero;

  modport source (output valid, output remainder, output remainder_zero, input ready);
  modport sink   (input valid, input remainder, input remainder_zero, output ready);
endinterface

@@ design/ccrc_regs.sv @@
module ccrc_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ccrc_pkg::APB_AW-1:0]     paddr,
  input  logic [ccrc_pkg::APB_DW-1:0]     pwdata,
  output logic [ccrc_pkg::APB_DW-1:0]     prdata,
  output logic                            pready,
  output ccrc_pkg::crc_cfg_t              cfg
);
  import ccrc_pkg::*;

  logic [WID_W-1:0] crc_width_r;
  logic [REM_W-1:0] poly_r;
  logic             wr_en;
  reg_idx_t         idx;
  logic [WID_W-1:0] w_eff;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_width_r <= CRC_WIDTH_RESET;
      poly_r      <= POLY_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_CRC_WIDTH: crc_width_r <= pwdata[WID_W-1:0];
        REG_POLY_LOW:  poly_r      <= pwdata[REM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CRC_WIDTH: prdata = {{(APB_DW-WID_W){1'b0}}, crc_width_r};
      REG_POLY_LOW:  prdata = poly_r;
      default:       prdata = '0;
    endcase
  end

  assign w_eff     = eff_width(crc_width_r);
  assign cfg.width = w_eff;
  assign cfg.mask  = width_mask(w_eff);
  assign cfg.poly  = poly_r & width_mask(w_eff);

endmodule

@@ design/ccrc_front.sv @@
module ccrc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  ccrc_in_if.sink               in_ch,
  output ccrc_pkg::queue_head_t head,
  input  logic                  pop
);
  import ccrc_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             do_pop;

  assign in_ch.ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head.valid  = (count_r != '0);
  assign head.item   = slots_r[rd_ptr_r];
  assign do_pop      = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r].data_byte <= in_ch.data_byte;
      slots_r[wr_ptr_r].last_byte <= in_ch.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ design/ccrc_back.sv @@
module ccrc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ccrc_pkg::crc_cfg_t    cfg,
  input  ccrc_pkg::queue_head_t head,
  output logic                  pop,
  ccrc_out_if.source            out_ch
);
  import ccrc_pkg::*;

  logic [REM_W-1:0] run_r;
  logic [REM_W-1:0] run_nxt;
  logic [REM_W-1:0] rem_r;
  logic             zero_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [REM_W-1:0] crc_next;
  logic [4:0]       top_idx;
  logic             fb;
  logic             emit;

  assign top_idx = 5'(cfg.width - 6'd1);

  // eight bit steps, MSB of the byte first
  always_comb begin
    crc_next = run_r & cfg.mask;
    for (int k = 7; k >= 0; k--) begin
      fb       = (cfg.width != '0) && (crc_next[top_idx] ^ head.item.data_byte[k]);
      crc_next = (crc_next << 1) & cfg.mask;
      if (fb) begin
        crc_next = crc_next ^ cfg.poly;
      end
    end
  end

  // a last byte waits until the result slot frees up
  assign pop  = head.valid && (!head.item.last_byte || !out_valid_r || out_ch.ready);
  assign emit = pop && head.item.last_byte;

  always_comb begin
    run_nxt = run_r;
    if (pop) begin
      run_nxt = head.item.last_byte ? '0 : crc_next;
    end
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rem_r  <= crc_next;
      zero_r <= (crc_next == '0);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.remainder      = rem_r;
  assign out_ch.remainder_zero = zero_r;

endmodule

@@ design/configurable_crc_remainder.sv @@
// MSB-first CRC remainder over a byte stream, initial value zero.
// in_ch carries one message byte per transaction plus last_byte; out_ch
// carries one result (remainder in the low crc_width bits, remainder_zero)
// per message, issued for the transaction that has last_byte set.
// The APB port holds crc_width (byte address 0) and poly_low_bits (address
// 4); write them only while no message is in flight.
// A two-entry queue sits between the input side and the CRC datapath. The
// datapath folds one byte per cycle into the running remainder with eight
// chained bit steps, so the block sustains one transaction per clock unless
// out_ch stalls. The result of a last byte is registered and drives out_ch.
// When out_ch stalls, the result register holds; non-last bytes keep
// draining into the remainder, a further last byte waits at the queue head,
// and in_ch.ready drops once both queue entries are full.
// Synchronous reset clears the queue, the running remainder and the result
// valid, and loads crc_width = 8 and poly_low_bits = 7.
module configurable_crc_remainder (
  input  logic                        clk,
  input  logic                        rst_n,
  ccrc_in_if.sink                     in_ch,
  ccrc_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ccrc_pkg::APB_AW-1:0] paddr,
  input  logic [ccrc_pkg::APB_DW-1:0] pwdata,
  output logic [ccrc_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import ccrc_pkg::*;

  crc_cfg_t    cfg;
  queue_head_t head;
  logic        pop;

  ccrc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ccrc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .head  (head),
    .pop   (pop)
  );

  ccrc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

@@ tb/configurable_crc_remainder_tb.sv @@
`timescale 1ns / 1ps

module configurable_crc_remainder_tb;
  import ccrc_pkg::*;

  localparam int unsigned RUN_LIMIT    = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned PHASE_ITEMS  = 75;
  localparam int unsigned MAX_REPORTS  = 40;

  typedef struct {
    logic [REM_W-1:0] remainder;
    logic             remainder_zero;
  } crc_result_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ccrc_in_if  in_if();
  ccrc_out_if out_if();

  configurable_crc_remainder i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the block's registers and running remainder
  logic [WID_W-1:0] cfg_width;
  logic [REM_W-1:0] cfg_poly;
  logic [REM_W-1:0] crc_state;

  item_t       pending_items[$];
  crc_result_t expected_remainders[$];

  int unsigned mismatches;
  int unsigned items_queued;
  int unsigned cycle_count;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned hold_requests;
  int unsigned holds_served;
  int unsigned hold_left;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $realtime, what);
    end
  endtask

  // eight MSB-first division steps of one byte at the given width and generator
  function automatic logic [REM_W-1:0] crc_fold(input logic [REM_W-1:0] rem,
                                                input logic [7:0] data,
                                                input logic [WID_W-1:0] width_raw,
                                                input logic [REM_W-1:0] poly_raw);
    int unsigned w;
    logic [REM_W-1:0] mask;
    logic [REM_W-1:0] poly;
    logic [REM_W-1:0] r;
    logic fb;
    w = (width_raw > WID_LIMIT) ? WID_LIMIT : width_raw;
    if (w == 0) return '0;
    mask = (w == REM_W) ? '1 : ((REM_W'(1) << w) - REM_W'(1));
    poly = poly_raw & mask;
    r = rem & mask;
    for (int k = 7; k >= 0; k--) begin
      fb = r[w-1] ^ data[k];
      r = (r << 1) & mask;
      if (fb) r = r ^ poly;
    end
    return r;
  endfunction

  task automatic absorb_byte(input logic [7:0] data, input logic last);
    crc_result_t res;
    crc_state = crc_fold(crc_state, data, cfg_width, cfg_poly);
    if (last) begin
      res.remainder = crc_state;
      res.remainder_zero = (crc_state == '0);
      expected_remainders.push_back(res);
      crc_state = '0;
    end
  endtask

  task automatic push_item(input logic [7:0] data, input logic last);
    item_t it;
    it.data_byte = data;
    it.last_byte = last;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // random message; check mode at width 8n appends the remainder: zero result
  task automatic queue_message(input int unsigned len, input bit check, input bit close);
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] shifted;
    logic [7:0] data;
    int unsigned ew;
    bit append;
    rem = '0;
    ew = (cfg_width > WID_LIMIT) ? WID_LIMIT : cfg_width;
    append = check && close && ew != 0 && (ew % 8) == 0;
    for (int unsigned i = 0; i < len; i++) begin
      data = 8'($urandom_range(255));
      rem = crc_fold(rem, data, cfg_width, cfg_poly);
      push_item(data, close && !append && i == len - 1);
    end
    if (append) begin
      for (int unsigned j = 0; j < ew / 8; j++) begin
        shifted = rem >> (ew - 8 * (j + 1));
        push_item(shifted[7:0], j == ew / 8 - 1);
      end
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CRC_WIDTH: cfg_width = value[WID_W-1:0];
      REG_POLY_LOW:  cfg_poly  = value[REM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_reg(input reg_idx_t idx);
    logic [APB_DW-1:0] want;
    want = (idx == REG_CRC_WIDTH) ? APB_DW'(cfg_width) : APB_DW'(cfg_poly);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      report_mismatch($sformatf("register %s read %h, want %h", idx.name(), prdata, want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [WID_W-1:0] w, input logic [REM_W-1:0] poly);
    write_reg(REG_CRC_WIDTH, {26'($urandom), w});
    write_reg(REG_POLY_LOW, poly);
    check_reg(REG_CRC_WIDTH);
    check_reg(REG_POLY_LOW);
  endtask

  // wait until every queued transaction is in and every result is out
  task automatic drain_block();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_if.valid || expected_remainders.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin : run_timer
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("configurable_crc_remainder_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin : drive_input
    logic held;
    held = in_if.valid && !in_if.ready;
    if (in_if.valid && in_if.ready) begin
      absorb_byte(in_if.data_byte, in_if.last_byte);
      void'(pending_items.pop_front());
    end
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!held) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= gap_pct) begin
        in_if.valid     <= 1'b1;
        in_if.data_byte <= pending_items[0].data_byte;
        in_if.last_byte <= pending_items[0].last_byte;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (holds_served != hold_requests) begin
        hold_left = HOLD_CYCLES;
        holds_served++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    crc_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_remainders.size() == 0) begin
        report_mismatch($sformatf("unexpected result remainder %h", out_if.remainder));
      end else begin
        want = expected_remainders.pop_front();
        if (out_if.remainder !== want.remainder) begin
          report_mismatch($sformatf("remainder %h, want %h", out_if.remainder, want.remainder));
        end
        if (out_if.remainder_zero !== want.remainder_zero) begin
          report_mismatch($sformatf("remainder_zero %b, want %b",
                                    out_if.remainder_zero, want.remainder_zero));
        end
      end
    end
  end

  initial begin : stimulus
    logic [WID_W-1:0] w;
    logic [REM_W-1:0] poly;
    int unsigned start;
    int unsigned len;
    bit pressure;
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    out_if.ready    = 1'b0;
    cfg_width       = CRC_WIDTH_RESET;
    cfg_poly        = POLY_RESET;
    crc_state       = '0;
    mismatches      = 0;
    items_queued    = 0;
    cycle_count     = 0;
    gap_pct         = 13;
    stall_pct       = 13;
    hold_requests   = 0;
    holds_served    = 0;
    hold_left       = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values, byte extremes, check mode, all-zero message
    check_reg(REG_CRC_WIDTH);
    check_reg(REG_POLY_LOW);
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b1);
    push_item(8'h80, 1'b1);
    push_item(8'h01, 1'b1);
    queue_message(3, 1'b1, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b1);
    drain_block();

    // full width: message shorter than the generator, and check mode
    configure(6'd32, 32'h04C1_1DB7);
    push_item(8'hA5, 1'b1);
    queue_message(2, 1'b1, 1'b1);
    drain_block();

    // zero width gives an empty remainder
    configure(6'd0, $urandom);
    push_item(8'hFF, 1'b1);
    push_item(8'h5A, 1'b1);
    drain_block();

    // oversized width saturates; leave a message open across the next change
    configure(6'd63, 32'hFFFF_FFFF);
    push_item(8'hFF, 1'b1);
    push_item(8'h9C, 1'b0);
    drain_block();

    // narrow width mid-message, generator bits above it ignored
    configure(6'd5, 32'hFFFF_FFF5);
    push_item(8'h3E, 1'b1);
    drain_block();

    configure(6'd1, 32'h0000_0001);
    push_item(8'hB7, 1'b0);
    push_item(8'h01, 1'b1);
    drain_block();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin w = 6'd1;  poly = $urandom; end
        1: begin w = 6'd32; poly = 32'hFFFF_FFFF; end
        2: begin w = 6'd0;  poly = $urandom; end
        3: begin w = 6'd63; poly = 32'h0000_0000; end
        4: begin w = 6'd16; poly = {16'($urandom), 16'h8005}; end
        default: begin
          w = ($urandom_range(99) < 80) ? 6'($urandom_range(1, 32)) : 6'($urandom_range(33, 63));
          poly = $urandom;
        end
      endcase
      if (p >= 6 && $urandom_range(3) == 0) begin
        write_reg(REG_POLY_LOW, poly);
        check_reg(REG_POLY_LOW);
      end else begin
        configure(w, poly);
      end
      gap_pct   = (p == 3) ? 0 : 13;
      stall_pct = (p == 3) ? 0 : 13;
      pressure  = (p == 5 || p == 8);
      if (pressure) hold_requests++;
      start = items_queued;
      while (items_queued - start < PHASE_ITEMS) begin
        if (pressure) len = $urandom_range(1, 3);
        else if ($urandom_range(9) == 0) len = $urandom_range(13, 40);
        else len = $urandom_range(1, 8);
        queue_message(len, $urandom_range(99) < 35, 1'b1);
      end
      // an open message carries into the next setting
      if (p != 9 && $urandom_range(2) == 0) begin
        queue_message($urandom_range(1, 3), 1'b0, 1'b0);
      end
      drain_block();
    end

    repeat (20) @(negedge clk);
    if (expected_remainders.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_remainders.size()));
    end
    if (mismatches == 0) begin
      $display("configurable_crc_remainder_tb OK");
    end else begin
      $display("configurable_crc_remainder_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ccrc_pkg.sv
design/ccrc_if.sv
design/ccrc_regs.sv
design/ccrc_front.sv
design/ccrc_back.sv
design/configurable_crc_remainder.sv
tb/configurable_crc_remainder_tb.sv
